>>> src/okv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okv_pkg
// Shared request, response and storage entry types for the optimistic
// transactional key-value store.
// ----------------------------------------------------------------------------
package okv_pkg;

   // Request actions
   localparam logic [2:0] ACT_BEGIN     = 3'd0;
   localparam logic [2:0] ACT_SET       = 3'd1;
   localparam logic [2:0] ACT_DELETE    = 3'd2;
   localparam logic [2:0] ACT_GET       = 3'd3;
   localparam logic [2:0] ACT_COMMIT    = 3'd4;
   localparam logic [2:0] ACT_RB_TXN    = 3'd5;
   localparam logic [2:0] ACT_RB_CLIENT = 3'd6;

   // Response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  client;
      logic [31:0] txn_ident;
      logic [63:0] key_word;
      logic [63:0] value_word;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] new_txn_ident;
      logic [63:0] read_value;
   } rsp_type;

   // Committed table entry
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] value;
      logic [63:0] generation;
   } tab_entry_type;

   // Read set entry: key and generation seen at first touch
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] generation;
   } rset_entry_type;

   // Write set entry: staged set or delete
   typedef struct packed {
      logic [63:0] key;
      logic [63:0] value;
      logic        del;
   } wset_entry_type;

endpackage
`default_nettype wire

>>> src/okv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okv_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output that holds between reads.
// ----------------------------------------------------------------------------
module okv_ram #(
   parameter int AW = 6,
   parameter int W  = 64
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [W-1:0]  rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [W-1:0]  wr_data
);

   logic [W-1:0] mem [1 << AW];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> src/occ_transactional_kv_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// occ_transactional_kv_store
// Key-value table with optimistic transactions. Table, read sets and write
// sets live in synchronous RAMs; a sequencer walks them entry by entry.
// ----------------------------------------------------------------------------
// Begin, rollback and bad actions answer from the dispatch state. Set,
// delete, get and commit scan the read set, write set and table RAMs; each
// scan step issues a RAM read, then compares the data it returns.
// One request at a time.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset sets counters to their start values and clears transaction slots directly; no clearing pass.
module occ_transactional_kv_store
   import okv_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int TXN_SLOTS   = 8,
   parameter int TXN_KEYS    = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);

   localparam int AWE = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int SW  = (TXN_SLOTS > 1) ? $clog2(TXN_SLOTS) : 1;
   localparam int KW  = (TXN_KEYS > 1) ? $clog2(TXN_KEYS) : 1;
   localparam int KCW = $clog2(TXN_KEYS + 1);
   localparam int IW  = (CW > KCW) ? CW : KCW;
   localparam int SAW = SW + KW;

   typedef enum logic [15:0] {
      S_IDLE        = 16'h0001,
      S_DISPATCH    = 16'h0002,
      S_SCAN        = 16'h0004,
      S_SCAN_WAIT   = 16'h0008,
      S_TOUCH       = 16'h0010,
      S_TOUCH_REC   = 16'h0020,
      S_AFTER_TOUCH = 16'h0040,
      S_WFOUND      = 16'h0080,
      S_GET_TAB     = 16'h0100,
      S_CHK         = 16'h0200,
      S_CHK_WAIT    = 16'h0400,
      S_CHK_CMP     = 16'h0800,
      S_APPLY       = 16'h1000,
      S_APPLY_WAIT  = 16'h2000,
      S_APPLY_DO    = 16'h4000,
      S_DEL_MOVE    = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      SEL_TAB,
      SEL_RS,
      SEL_WS
   } sel_type;

   // Sequencer state
   state_type state_ff, state_in, ret_ff, ret_in;
   sel_type   sel_ff, sel_in;
   req_type   req_ff, req_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic [IW-1:0]  idx_ff, idx_in, lim_ff, lim_in, pos_ff, pos_in;
   logic [63:0]    skey_ff, skey_in;
   logic           found_ff, found_in;
   logic [KCW-1:0] ci_ff, ci_in;

   // Global counters
   logic [CW-1:0]  count_ff, count_in;
   logic [63:0]    gen_ff, gen_in;
   logic [31:0]    txn_ff, txn_in;

   // Transaction slots
   logic           slot_busy_ff [TXN_SLOTS];
   logic           slot_busy_in [TXN_SLOTS];
   logic [7:0]     slot_client_ff [TXN_SLOTS];
   logic [7:0]     slot_client_in [TXN_SLOTS];
   logic [31:0]    slot_txn_ff [TXN_SLOTS];
   logic [31:0]    slot_txn_in [TXN_SLOTS];
   logic [KCW-1:0] slot_rc_ff [TXN_SLOTS];
   logic [KCW-1:0] slot_rc_in [TXN_SLOTS];
   logic [KCW-1:0] slot_wc_ff [TXN_SLOTS];
   logic [KCW-1:0] slot_wc_in [TXN_SLOTS];

   // Response
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;
   logic    done_c, ok_c;
   logic [31:0] nid_c;
   logic [63:0] rdv_c;

   // Slot lookup
   logic          hit_c, free_c;
   logic [SW-1:0] hit_slot_c, free_slot_c;

   // RAM ports
   logic           tab_rd_en, tab_wr_en;
   logic [AWE-1:0] tab_rd_addr, tab_wr_addr;
   tab_entry_type  tab_rdata, tab_wdata;
   logic           rs_rd_en, rs_wr_en;
   logic [SAW-1:0] rs_rd_addr, rs_wr_addr;
   rset_entry_type rs_rdata, rs_wdata;
   logic           ws_rd_en, ws_wr_en;
   logic [SAW-1:0] ws_rd_addr, ws_wr_addr;
   wset_entry_type ws_rdata, ws_wdata;

   logic [63:0]    cmp_key_c;
   logic [63:0]    seen_gen_c;

   okv_ram #(.AW(AWE), .W($bits(tab_entry_type))) u_tab (
      .clock   (clock),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rdata),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wdata)
   );

   okv_ram #(.AW(SAW), .W($bits(rset_entry_type))) u_rset (
      .clock   (clock),
      .rd_en   (rs_rd_en),
      .rd_addr (rs_rd_addr),
      .rd_data (rs_rdata),
      .wr_en   (rs_wr_en),
      .wr_addr (rs_wr_addr),
      .wr_data (rs_wdata)
   );

   okv_ram #(.AW(SAW), .W($bits(wset_entry_type))) u_wset (
      .clock   (clock),
      .rd_en   (ws_rd_en),
      .rd_addr (ws_rd_addr),
      .rd_data (ws_rdata),
      .wr_en   (ws_wr_en),
      .wr_addr (ws_wr_addr),
      .wr_data (ws_wdata)
   );

   // Find the lowest slot holding the transaction, and the lowest free slot
   always_comb begin
      hit_c       = 1'b0;
      hit_slot_c  = '0;
      free_c      = 1'b0;
      free_slot_c = '0;
      for (int s = TXN_SLOTS - 1; s >= 0; s--) begin
         if (slot_busy_ff[s] && slot_txn_ff[s] == req_ff.txn_ident) begin
            hit_c      = 1'b1;
            hit_slot_c = SW'(s);
         end
         if (!slot_busy_ff[s]) begin
            free_c      = 1'b1;
            free_slot_c = SW'(s);
         end
      end
   end

   // Key of the element just read by the scan
   always_comb begin
      case (sel_ff)
         SEL_TAB: cmp_key_c = tab_rdata.key;
         SEL_RS:  cmp_key_c = rs_rdata.key;
         SEL_WS:  cmp_key_c = ws_rdata.key;
         default: cmp_key_c = tab_rdata.key;
      endcase
   end

   // Generation of the last table lookup, zero if the key was absent
   assign seen_gen_c = found_ff ? tab_rdata.generation : 64'd0;

   // Sequencer: every RAM access is issued here, so a table write and a later
   // read of the same entry never share a cycle and need no forwarding.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      sel_in   = sel_ff;
      req_in   = req_ff;
      slot_in  = slot_ff;
      idx_in   = idx_ff;
      lim_in   = lim_ff;
      pos_in   = pos_ff;
      skey_in  = skey_ff;
      found_in = found_ff;
      ci_in    = ci_ff;
      count_in = count_ff;
      gen_in   = gen_ff;
      txn_in   = txn_ff;
      slot_busy_in   = slot_busy_ff;
      slot_client_in = slot_client_ff;
      slot_txn_in    = slot_txn_ff;
      slot_rc_in     = slot_rc_ff;
      slot_wc_in     = slot_wc_ff;
      done_c = 1'b0;
      ok_c   = 1'b0;
      nid_c  = '0;
      rdv_c  = '0;
      tab_rd_en   = 1'b0;
      tab_rd_addr = idx_ff[AWE-1:0];
      tab_wr_en   = 1'b0;
      tab_wr_addr = pos_ff[AWE-1:0];
      tab_wdata   = '{key: ws_rdata.key, value: ws_rdata.value, generation: gen_ff};
      rs_rd_en    = 1'b0;
      rs_rd_addr  = {slot_ff, idx_ff[KW-1:0]};
      rs_wr_en    = 1'b0;
      rs_wr_addr  = {slot_ff, slot_rc_ff[slot_ff][KW-1:0]};
      rs_wdata    = '{key: req_ff.key_word, generation: seen_gen_c};
      ws_rd_en    = 1'b0;
      ws_rd_addr  = {slot_ff, idx_ff[KW-1:0]};
      ws_wr_en    = 1'b0;
      ws_wr_addr  = {slot_ff, slot_wc_ff[slot_ff][KW-1:0]};
      ws_wdata    = '{key: req_ff.key_word,
                      value: (req_ff.action == ACT_DELETE) ? 64'd0 : req_ff.value_word,
                      del: (req_ff.action == ACT_DELETE)};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            case (req_ff.action)
               ACT_BEGIN: begin
                  done_c   = 1'b1;
                  state_in = S_IDLE;
                  if (free_c) begin
                     slot_busy_in[free_slot_c]   = 1'b1;
                     slot_client_in[free_slot_c] = req_ff.client;
                     slot_txn_in[free_slot_c]    = txn_ff;
                     slot_rc_in[free_slot_c]     = '0;
                     slot_wc_in[free_slot_c]     = '0;
                     txn_in = txn_ff + 32'd1;
                     ok_c   = 1'b1;
                     nid_c  = txn_ff;
                  end
               end
               ACT_SET, ACT_DELETE, ACT_GET: begin
                  if (!hit_c || (req_ff.action == ACT_SET && req_ff.key_word == 64'd0)) begin
                     done_c   = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     // Look the key up in the read set first
                     slot_in  = hit_slot_c;
                     sel_in   = SEL_RS;
                     idx_in   = '0;
                     lim_in   = IW'(slot_rc_ff[hit_slot_c]);
                     skey_in  = req_ff.key_word;
                     ret_in   = S_TOUCH;
                     state_in = S_SCAN;
                  end
               end
               ACT_COMMIT: begin
                  if (!hit_c) begin
                     done_c   = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     slot_in  = hit_slot_c;
                     ci_in    = '0;
                     state_in = S_CHK;
                  end
               end
               ACT_RB_TXN: begin
                  if (hit_c) begin
                     slot_busy_in[hit_slot_c] = 1'b0;
                     slot_txn_in[hit_slot_c]  = '0;
                     slot_rc_in[hit_slot_c]   = '0;
                     slot_wc_in[hit_slot_c]   = '0;
                  end
                  done_c   = 1'b1;
                  ok_c     = 1'b1;
                  state_in = S_IDLE;
               end
               ACT_RB_CLIENT: begin
                  for (int s = 0; s < TXN_SLOTS; s++) begin
                     if (slot_busy_ff[s] && slot_client_ff[s] == req_ff.client) begin
                        slot_busy_in[s] = 1'b0;
                        slot_txn_in[s]  = '0;
                        slot_rc_in[s]   = '0;
                        slot_wc_in[s]   = '0;
                     end
                  end
                  done_c   = 1'b1;
                  ok_c     = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  done_c   = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end

         // Issue a read of the next element, or stop at the limit
         S_SCAN: begin
            if (idx_ff >= lim_ff) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               case (sel_ff)
                  SEL_TAB: tab_rd_en = 1'b1;
                  SEL_RS:  rs_rd_en  = 1'b1;
                  SEL_WS:  ws_rd_en  = 1'b1;
                  default: tab_rd_en = 1'b1;
               endcase
               state_in = S_SCAN_WAIT;
            end
         end

         // Compare the element read last cycle; its data stays on the RAM output
         S_SCAN_WAIT: begin
            if (cmp_key_c == skey_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
               state_in = ret_ff;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SCAN;
            end
         end

         S_TOUCH: begin
            if (found_ff) begin
               state_in = S_AFTER_TOUCH;
            end else if (slot_rc_ff[slot_ff] == KCW'(TXN_KEYS)) begin
               done_c   = 1'b1;
               state_in = S_IDLE;
            end else begin
               sel_in   = SEL_TAB;
               idx_in   = '0;
               lim_in   = IW'(count_ff);
               ret_in   = S_TOUCH_REC;
               state_in = S_SCAN;
            end
         end

         // Record the key with the generation just found
         S_TOUCH_REC: begin
            rs_wr_en            = 1'b1;
            slot_rc_in[slot_ff] = slot_rc_ff[slot_ff] + KCW'(1);
            state_in            = S_AFTER_TOUCH;
         end

         S_AFTER_TOUCH: begin
            sel_in   = SEL_WS;
            idx_in   = '0;
            lim_in   = IW'(slot_wc_ff[slot_ff]);
            skey_in  = req_ff.key_word;
            ret_in   = S_WFOUND;
            state_in = S_SCAN;
         end

         S_WFOUND: begin
            if (req_ff.action == ACT_GET) begin
               if (found_ff) begin
                  done_c   = 1'b1;
                  ok_c     = !ws_rdata.del;
                  rdv_c    = ws_rdata.value;
                  state_in = S_IDLE;
               end else begin
                  sel_in   = SEL_TAB;
                  idx_in   = '0;
                  lim_in   = IW'(count_ff);
                  ret_in   = S_GET_TAB;
                  state_in = S_SCAN;
               end
            end else begin
               done_c   = 1'b1;
               state_in = S_IDLE;
               if (found_ff) begin
                  ws_wr_en   = 1'b1;
                  ws_wr_addr = {slot_ff, pos_ff[KW-1:0]};
                  ok_c       = 1'b1;
               end else if (slot_wc_ff[slot_ff] != KCW'(TXN_KEYS)) begin
                  ws_wr_en            = 1'b1;
                  slot_wc_in[slot_ff] = slot_wc_ff[slot_ff] + KCW'(1);
                  ok_c                = 1'b1;
               end
            end
         end

         S_GET_TAB: begin
            done_c   = 1'b1;
            ok_c     = found_ff;
            rdv_c    = tab_rdata.value;
            state_in = S_IDLE;
         end

         // Validate the read set, one recorded key at a time
         S_CHK: begin
            if (ci_ff == slot_rc_ff[slot_ff]) begin
               ci_in    = '0;
               state_in = S_APPLY;
            end else begin
               rs_rd_en   = 1'b1;
               rs_rd_addr = {slot_ff, ci_ff[KW-1:0]};
               state_in   = S_CHK_WAIT;
            end
         end

         S_CHK_WAIT: begin
            sel_in   = SEL_TAB;
            idx_in   = '0;
            lim_in   = IW'(count_ff);
            skey_in  = rs_rdata.key;
            ret_in   = S_CHK_CMP;
            state_in = S_SCAN;
         end

         S_CHK_CMP: begin
            if (seen_gen_c != rs_rdata.generation) begin
               slot_busy_in[slot_ff] = 1'b0;
               slot_txn_in[slot_ff]  = '0;
               slot_rc_in[slot_ff]   = '0;
               slot_wc_in[slot_ff]   = '0;
               done_c   = 1'b1;
               state_in = S_IDLE;
            end else begin
               ci_in    = ci_ff + KCW'(1);
               state_in = S_CHK;
            end
         end

         // Apply staged writes in order
         S_APPLY: begin
            if (ci_ff == slot_wc_ff[slot_ff]) begin
               slot_busy_in[slot_ff] = 1'b0;
               slot_txn_in[slot_ff]  = '0;
               slot_rc_in[slot_ff]   = '0;
               slot_wc_in[slot_ff]   = '0;
               done_c   = 1'b1;
               ok_c     = 1'b1;
               state_in = S_IDLE;
            end else begin
               ws_rd_en   = 1'b1;
               ws_rd_addr = {slot_ff, ci_ff[KW-1:0]};
               state_in   = S_APPLY_WAIT;
            end
         end

         S_APPLY_WAIT: begin
            sel_in   = SEL_TAB;
            idx_in   = '0;
            lim_in   = IW'(count_ff);
            skey_in  = ws_rdata.key;
            ret_in   = S_APPLY_DO;
            state_in = S_SCAN;
         end

         S_APPLY_DO: begin
            if (ws_rdata.del) begin
               if (found_ff) begin
                  // Fetch the last entry to move into the freed place
                  tab_rd_en   = 1'b1;
                  tab_rd_addr = AWE'(count_ff - CW'(1));
                  state_in    = S_DEL_MOVE;
               end else begin
                  ci_in    = ci_ff + KCW'(1);
                  state_in = S_APPLY;
               end
            end else if (found_ff) begin
               tab_wr_en = 1'b1;
               gen_in    = gen_ff + 64'd1;
               ci_in     = ci_ff + KCW'(1);
               state_in  = S_APPLY;
            end else if (count_ff == CW'(MAX_ENTRIES)) begin
               slot_busy_in[slot_ff] = 1'b0;
               slot_txn_in[slot_ff]  = '0;
               slot_rc_in[slot_ff]   = '0;
               slot_wc_in[slot_ff]   = '0;
               done_c   = 1'b1;
               state_in = S_IDLE;
            end else begin
               tab_wr_en   = 1'b1;
               tab_wr_addr = AWE'(count_ff);
               count_in    = count_ff + CW'(1);
               gen_in      = gen_ff + 64'd1;
               ci_in       = ci_ff + KCW'(1);
               state_in    = S_APPLY;
            end
         end

         S_DEL_MOVE: begin
            tab_wr_en = 1'b1;
            tab_wdata = tab_rdata;
            count_in  = count_ff - CW'(1);
            ci_in     = ci_ff + KCW'(1);
            state_in  = S_APPLY;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         gen_ff        <= 64'd1;
         txn_ff        <= 32'd1;
         rsp_strobe_ff <= 1'b0;
         for (int s = 0; s < TXN_SLOTS; s++) begin
            slot_busy_ff[s] <= 1'b0;
            slot_txn_ff[s]  <= '0;
            slot_rc_ff[s]   <= '0;
            slot_wc_ff[s]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         gen_ff        <= gen_in;
         txn_ff        <= txn_in;
         rsp_strobe_ff <= done_c;
         slot_busy_ff  <= slot_busy_in;
         slot_txn_ff   <= slot_txn_in;
         slot_rc_ff    <= slot_rc_in;
         slot_wc_ff    <= slot_wc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ret_ff         <= ret_in;
      sel_ff         <= sel_in;
      req_ff         <= req_in;
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      lim_ff         <= lim_in;
      pos_ff         <= pos_in;
      skey_ff        <= skey_in;
      found_ff       <= found_in;
      ci_ff          <= ci_in;
      slot_client_ff <= slot_client_in;
      if (done_c) begin
         rsp_data_ff.status        <= ok_c ? STATUS_OK : STATUS_FAIL;
         rsp_data_ff.new_txn_ident <= ok_c ? nid_c : 32'd0;
         rsp_data_ff.read_value    <= ok_c ? rdv_c : 64'd0;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The result beat appears only once the sequencer is back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // No request answers in the cycle right after it is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result beat too early");

   // Table never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count overflow");

   // Table read and write never overlap
   a_tab_interlock: assert property (@(posedge clock) disable iff (reset)
      !(tab_rd_en && tab_wr_en))
      else $error("table read and write in one cycle");

   // Set sizes of the active slot stay within bounds once a slot is selected
   a_set_bound: assert property (@(posedge clock) disable iff (reset)
      (busy && state_ff != S_DISPATCH) |->
         (slot_rc_ff[slot_ff] <= KCW'(TXN_KEYS) &&
          slot_wc_ff[slot_ff] <= KCW'(TXN_KEYS)))
      else $error("transaction set overflow");

endmodule
`default_nettype wire

>>> test/okv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okv_checker
// Watches the request and response channels of the transactional key-value
// store, keeps its own copy of table and transaction state, and compares
// every response beat field by field with the predicted one.
// ----------------------------------------------------------------------------
module okv_checker
   import okv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   localparam int NUM_ENTRIES = 64;
   localparam int NUM_SLOTS   = 8;
   localparam int SET_KEYS    = 16;

   logic [63:0] tab_key [NUM_ENTRIES];
   logic [63:0] tab_val [NUM_ENTRIES];
   logic [63:0] tab_gen [NUM_ENTRIES];
   int          tab_count;
   logic [63:0] gen_next;
   logic [31:0] txn_next;
   logic        slot_used [NUM_SLOTS];
   logic [7:0]  slot_owner [NUM_SLOTS];
   logic [31:0] slot_id [NUM_SLOTS];
   int          rd_count [NUM_SLOTS];
   int          wr_count [NUM_SLOTS];
   logic [63:0] rd_key [NUM_SLOTS][SET_KEYS];
   logic [63:0] rd_gen [NUM_SLOTS][SET_KEYS];
   logic [63:0] wr_key [NUM_SLOTS][SET_KEYS];
   logic [63:0] wr_val [NUM_SLOTS][SET_KEYS];
   logic        wr_del [NUM_SLOTS][SET_KEYS];

   rsp_type expected_rsps [$];

   function automatic int table_index(logic [63:0] key);
      for (int i = 0; i < tab_count; i++)
         if (tab_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int slot_of(logic [31:0] id);
      for (int s = 0; s < NUM_SLOTS; s++)
         if (slot_used[s] && slot_id[s] == id) return s;
      return -1;
   endfunction

   function automatic void release_slot(int s);
      slot_used[s] = 1'b0;
      slot_id[s] = '0;
      rd_count[s] = 0;
      wr_count[s] = 0;
   endfunction

   // Record the key's generation at first touch; 0 when the read set is full.
   function automatic bit note_read(int s, logic [63:0] key);
      int e;
      for (int i = 0; i < rd_count[s]; i++)
         if (rd_key[s][i] == key) return 1;
      if (rd_count[s] >= SET_KEYS) return 0;
      e = table_index(key);
      rd_key[s][rd_count[s]] = key;
      rd_gen[s][rd_count[s]] = (e >= 0) ? tab_gen[e] : 64'd0;
      rd_count[s]++;
      return 1;
   endfunction

   function automatic int staged_index(int s, logic [63:0] key);
      for (int i = 0; i < wr_count[s]; i++)
         if (wr_key[s][i] == key) return i;
      return -1;
   endfunction

   function automatic bit stage_write(int s, logic [63:0] key, logic [63:0] val, bit del);
      int w;
      if (!note_read(s, key)) return 0;
      w = staged_index(s, key);
      if (w < 0) begin
         if (wr_count[s] >= SET_KEYS) return 0;
         w = wr_count[s];
         wr_count[s]++;
         wr_key[s][w] = key;
      end
      wr_val[s][w] = del ? 64'd0 : val;
      wr_del[s][w] = del;
      return 1;
   endfunction

   // Validate the read set, then apply staged writes in order.
   function automatic bit apply_commit(int s);
      int e;
      logic [63:0] g;
      for (int i = 0; i < rd_count[s]; i++) begin
         e = table_index(rd_key[s][i]);
         g = (e >= 0) ? tab_gen[e] : 64'd0;
         if (g != rd_gen[s][i]) begin
            release_slot(s);
            return 0;
         end
      end
      for (int i = 0; i < wr_count[s]; i++) begin
         e = table_index(wr_key[s][i]);
         if (wr_del[s][i]) begin
            if (e >= 0) begin
               tab_key[e] = tab_key[tab_count-1];
               tab_val[e] = tab_val[tab_count-1];
               tab_gen[e] = tab_gen[tab_count-1];
               tab_count--;
            end
         end else begin
            if (e < 0) begin
               if (tab_count >= NUM_ENTRIES) begin
                  release_slot(s);
                  return 0;
               end
               e = tab_count;
               tab_count++;
               tab_key[e] = wr_key[s][i];
            end
            tab_val[e] = wr_val[s][i];
            tab_gen[e] = gen_next;
            gen_next++;
         end
      end
      release_slot(s);
      return 1;
   endfunction

   function automatic rsp_type predict_response(req_type rq);
      rsp_type r;
      bit ok;
      int s, w, e;
      ok = 0;
      r = '0;
      case (rq.action)
         ACT_BEGIN: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (!ok && !slot_used[i]) begin
                  release_slot(i);
                  slot_used[i] = 1'b1;
                  slot_owner[i] = rq.client;
                  slot_id[i] = txn_next;
                  r.new_txn_ident = txn_next;
                  txn_next++;
                  ok = 1;
               end
         end
         ACT_SET: begin
            s = slot_of(rq.txn_ident);
            if (s >= 0 && rq.key_word != 0)
               ok = stage_write(s, rq.key_word, rq.value_word, 0);
         end
         ACT_DELETE: begin
            s = slot_of(rq.txn_ident);
            if (s >= 0) ok = stage_write(s, rq.key_word, 64'd0, 1);
         end
         ACT_GET: begin
            s = slot_of(rq.txn_ident);
            if (s >= 0 && note_read(s, rq.key_word)) begin
               w = staged_index(s, rq.key_word);
               if (w >= 0) begin
                  if (!wr_del[s][w]) begin
                     r.read_value = wr_val[s][w];
                     ok = 1;
                  end
               end else begin
                  e = table_index(rq.key_word);
                  if (e >= 0) begin
                     r.read_value = tab_val[e];
                     ok = 1;
                  end
               end
            end
         end
         ACT_COMMIT: begin
            s = slot_of(rq.txn_ident);
            if (s >= 0) ok = apply_commit(s);
         end
         ACT_RB_TXN: begin
            s = slot_of(rq.txn_ident);
            if (s >= 0) release_slot(s);
            ok = 1;
         end
         ACT_RB_CLIENT: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_used[i] && slot_owner[i] == rq.client) release_slot(i);
            ok = 1;
         end
         default: ok = 0;
      endcase
      if (!ok) r = '0;
      r.status = ok ? STATUS_OK : STATUS_FAIL;
      return r;
   endfunction

   // Predict on each accepted request, compare on each response beat.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         tab_count <= 0;
         gen_next <= 64'd1;
         txn_next <= 32'd1;
         for (int s = 0; s < NUM_SLOTS; s++) release_slot(s);
         expected_rsps.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data.status !== exp_rsp.status ||
                   rsp_data.new_txn_ident !== exp_rsp.new_txn_ident ||
                   rsp_data.read_value !== exp_rsp.read_value) begin
                  $display({"%0t: response mismatch: expected st=%b id=%h rd=%h,",
                            " actual st=%b id=%h rd=%h"},
                           $realtime, exp_rsp.status, exp_rsp.new_txn_ident,
                           exp_rsp.read_value, rsp_data.status,
                           rsp_data.new_txn_ident, rsp_data.read_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) expected_rsps.push_back(predict_response(req_data));
         pending_count <= expected_rsps.size();
      end
   end

endmodule

>>> test/tb_occ_transactional_kv_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occ_transactional_kv_store
// Drives directed and random transaction traffic into the key-value store
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_occ_transactional_kv_store;
   import okv_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count;

   logic [31:0] open_txns [$];
   logic [63:0] key_pool [8];

   occ_transactional_kv_store i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   okv_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Enforce the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Track identifiers handed out by begin so later requests hit open slots.
   always @(posedge clock) begin
      if (!reset && rsp_strobe && rsp_data.status == STATUS_OK &&
          rsp_data.new_txn_ident != 0) begin
         open_txns.push_back(rsp_data.new_txn_ident);
         if (open_txns.size() > 12) void'(open_txns.pop_front());
      end
   end

   // Issue one request beat, holding start until accepted. The block is busy
   // after each accept, so start drops there first.
   task automatic send_request(req_type rq, int gap);
      repeat (gap + 1) @(posedge clock);
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
   endtask

   // Wait until every expected result has come and the tracking has settled.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_txn();
      if (open_txns.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
      return open_txns[$urandom_range(0, open_txns.size() - 1)];
   endfunction

   function automatic req_type make_op(logic [2:0] act, logic [31:0] id, logic [63:0] key,
                                       logic [63:0] val, logic [7:0] cl);
      req_type rq;
      rq.action = act;
      rq.client = cl;
      rq.txn_ident = id;
      rq.key_word = key;
      rq.value_word = val;
      return rq;
   endfunction

   function automatic req_type random_request();
      int pick;
      logic [2:0] act;
      logic [63:0] key;
      pick = $urandom_range(0, 99);
      if (pick < 12) act = ACT_BEGIN;
      else if (pick < 40) act = ACT_SET;
      else if (pick < 50) act = ACT_DELETE;
      else if (pick < 68) act = ACT_GET;
      else if (pick < 88) act = ACT_COMMIT;
      else if (pick < 94) act = ACT_RB_TXN;
      else if (pick < 97) act = ACT_RB_CLIENT;
      else act = 3'd7;
      case ($urandom_range(0, 9))
         0: key = {$urandom, $urandom};
         1: key = '0;
         2: key = 64'(int'($urandom_range(1, 200)));
         default: key = key_pool[$urandom_range(0, 7)];
      endcase
      return make_op(act, pick_txn(), key, {$urandom, $urandom}, 8'($urandom_range(0, 3)));
   endfunction

   initial begin
      logic [31:0] tid;
      int sent;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: unknown action, field extremes, every action, empty key.
      send_request(make_op(3'd7, '1, '1, '1, '1), 0);
      send_request(make_op(ACT_SET, 32'd5, 64'd1, 64'd1, 8'd0), 0);
      send_request(make_op(ACT_BEGIN, '0, '0, '0, 8'hFF), 0);
      wait_drained();
      tid = open_txns[$];
      send_request(make_op(ACT_SET, tid, '0, '1, 8'd0), 0);
      send_request(make_op(ACT_SET, tid, '1, '1, 8'd0), 1);
      send_request(make_op(ACT_GET, tid, '1, '0, 8'd0), 0);
      send_request(make_op(ACT_GET, tid, '0, '0, 8'd0), 0);
      send_request(make_op(ACT_DELETE, tid, 64'd7, '0, 8'd0), 2);
      send_request(make_op(ACT_GET, tid, 64'd7, '0, 8'd0), 0);
      send_request(make_op(ACT_COMMIT, tid, '0, '0, 8'd0), 0);
      send_request(make_op(ACT_COMMIT, tid, '0, '0, 8'd0), 0);
      // Fill all slots, overflow begin, then client rollback.
      for (int i = 0; i < 9; i++)
         send_request(make_op(ACT_BEGIN, '0, '0, '0, 8'(i & 1)), 0);
      send_request(make_op(ACT_RB_CLIENT, '0, '0, '0, 8'd1), 0);
      send_request(make_op(ACT_RB_TXN, 32'hDEAD_BEEF, '0, '0, 8'd0), 0);
      send_request(make_op(ACT_RB_CLIENT, '0, '0, '0, 8'd0), 0);
      wait_drained();
      open_txns.delete();

      // Read set overflow, then commits that fill the table.
      send_request(make_op(ACT_BEGIN, '0, '0, '0, 8'd9), 0);
      wait_drained();
      tid = open_txns[$];
      for (int i = 0; i < 18; i++)
         send_request(make_op(ACT_SET, tid, 64'(1000 + i), 64'(i), 8'd0), 0);
      send_request(make_op(ACT_COMMIT, tid, '0, '0, 8'd0), 0);
      for (int r = 0; r < 5; r++) begin
         send_request(make_op(ACT_BEGIN, '0, '0, '0, 8'd9), 0);
         wait_drained();
         tid = open_txns[$];
         for (int i = 0; i < 16; i++)
            send_request(make_op(ACT_SET, tid, 64'(2000 + 16 * r + i), {$urandom, $urandom},
                                 8'd0), 0);
         send_request(make_op(ACT_COMMIT, tid, '0, '0, 8'd0), 0);
      end
      wait_drained();

      // Random traffic: mostly well-formed transactions, some noise.
      sent = 0;
      while (sent < 700) begin
         if ($urandom_range(0, 3) == 0) begin
            send_request(make_op(ACT_BEGIN, '0, '0, '0, 8'($urandom_range(0, 3))),
                         $urandom_range(0, 19));
            wait_drained();
            tid = open_txns.size() ? open_txns[$] : 32'd0;
            repeat ($urandom_range(1, 6)) begin
               send_request(make_op($urandom_range(0, 2) == 0 ? ACT_GET :
                                    ($urandom_range(0, 4) == 0 ? ACT_DELETE : ACT_SET),
                                    tid, key_pool[$urandom_range(0, 7)],
                                    {$urandom, $urandom}, 8'd0),
                            $urandom_range(0, 1) ? 0 : $urandom_range(0, 19));
               sent++;
            end
            send_request(make_op(ACT_COMMIT, tid, '0, '0, 8'd0), $urandom_range(0, 19));
            sent += 2;
         end else begin
            send_request(random_request(), $urandom_range(0, 1) ? 0 : $urandom_range(0, 19));
            sent++;
         end
         if ($urandom_range(0, 99) == 0) wait_drained();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
src/okv_pkg.sv
src/okv_ram.sv
src/occ_transactional_kv_store.sv
test/okv_checker.sv
test/tb_occ_transactional_kv_store.sv
